// ===== rtl/hles_pkg.sv =====
// Shared types, codes and text tables for the HTML text line escaper.
// Used by hles_emitter and html_text_line_escaper; no dependencies.

package hles_pkg;

    // Leading part of an output run
    localparam logic [1:0] LEAD_NONE  = 2'd0;
    localparam logic [1:0] LEAD_SPACE = 2'd1;
    localparam logic [1:0] LEAD_NBSP1 = 2'd2;
    localparam logic [1:0] LEAD_NBSP2 = 2'd3;

    // Body part: the escaped form of the text byte
    localparam logic [2:0] BODY_NONE  = 3'd0;
    localparam logic [2:0] BODY_PLAIN = 3'd1;
    localparam logic [2:0] BODY_AMP   = 3'd2;
    localparam logic [2:0] BODY_LT    = 3'd3;
    localparam logic [2:0] BODY_GT    = 3'd4;
    localparam logic [2:0] BODY_QUOT  = 3'd5;
    localparam logic [2:0] BODY_APOS  = 3'd6;
    localparam logic [2:0] BODY_BR    = 3'd7;

    // Emission phases, walked in this order
    localparam logic [1:0] PH_LEAD = 2'd0;
    localparam logic [1:0] PH_BODY = 2'd1;
    localparam logic [1:0] PH_TSP  = 2'd2;
    localparam logic [1:0] PH_TBR  = 2'd3;

    // Character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Entity texts, right-justified in 48 bits
    localparam logic [47:0] STR_AMP  = "&amp;";
    localparam logic [47:0] STR_LT   = "&lt;";
    localparam logic [47:0] STR_GT   = "&gt;";
    localparam logic [47:0] STR_QUOT = "&quot;";
    localparam logic [47:0] STR_APOS = "&#39;";
    localparam logic [47:0] STR_BR   = "<br />";
    localparam logic [47:0] STR_NBSP = "&nbsp;";

    // Plan for the output bytes caused by one input transaction
    typedef struct packed {
        logic [1:0] lead;
        logic [2:0] body;
        logic [7:0] ch;
        logic       tsp;
        logic       tbr;
    } t_plan;

    // Character i of a right-justified string of length len
    function automatic logic [7:0] str_char(logic [47:0] s, logic [2:0] len, logic [2:0] i);
        logic [2:0] k;
        k = len - 3'd1 - i;
        return 8'(s >> {k, 3'b000});
    endfunction

    // Length of one phase of a plan
    function automatic logic [3:0] seg_len(t_plan p, logic [1:0] ph);
        logic [3:0] r;
        r = 4'd0;
        unique case (ph)
            PH_LEAD: begin
                unique case (p.lead)
                    LEAD_NONE:  r = 4'd0;
                    LEAD_SPACE: r = 4'd1;
                    LEAD_NBSP1: r = 4'd6;
                    LEAD_NBSP2: r = 4'd12;
                    default:    r = 4'd0;
                endcase
            end
            PH_BODY: begin
                unique case (p.body)
                    BODY_NONE:  r = 4'd0;
                    BODY_PLAIN: r = 4'd1;
                    BODY_AMP:   r = 4'd5;
                    BODY_LT:    r = 4'd4;
                    BODY_GT:    r = 4'd4;
                    BODY_QUOT:  r = 4'd6;
                    BODY_APOS:  r = 4'd5;
                    BODY_BR:    r = 4'd6;
                    default:    r = 4'd0;
                endcase
            end
            PH_TSP:  r = {3'd0, p.tsp};
            PH_TBR:  r = p.tbr ? 4'd6 : 4'd0;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    // Output byte at position idx of a phase
    function automatic logic [7:0] seg_char(t_plan p, logic [1:0] ph, logic [3:0] idx);
        logic [7:0] r;
        logic [2:0] i;
        // second &nbsp; of a pair restarts at its first character
        i = (idx >= 4'd6) ? 3'(idx - 4'd6) : idx[2:0];
        r = CH_NUL;
        unique case (ph)
            PH_LEAD: r = (p.lead == LEAD_SPACE) ? CH_SPACE : str_char(STR_NBSP, 3'd6, i);
            PH_BODY: begin
                unique case (p.body)
                    BODY_AMP:  r = str_char(STR_AMP, 3'd5, i);
                    BODY_LT:   r = str_char(STR_LT, 3'd4, i);
                    BODY_GT:   r = str_char(STR_GT, 3'd4, i);
                    BODY_QUOT: r = str_char(STR_QUOT, 3'd6, i);
                    BODY_APOS: r = str_char(STR_APOS, 3'd5, i);
                    BODY_BR:   r = str_char(STR_BR, 3'd6, i);
                    default:   r = p.ch;
                endcase
            end
            PH_TSP:  r = CH_SPACE;
            PH_TBR:  r = str_char(STR_BR, 3'd6, i);
            default: r = CH_NUL;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/html_text_line_escaper.sv =====
// Top level of the HTML text line escaper: space tracking and plan building.
// Depends on hles_pkg and hles_emitter.
//
// Usage:
//   Input stream (s): one text byte per transaction in tdata, tlast marks
//   the last byte of a line string. Output stream (m): one escaped HTML
//   byte per transaction in tdata, tlast marks the last byte caused by an
//   input byte.
//   Each input byte is turned into a plan (held space, escaped byte,
//   trailing space and line break) that the emitter walks one byte a
//   cycle while the receiver is ready. Output bytes pass through the
//   plan register and then the output register. A new plan is taken
//   only with the last byte of the one before, so plain text flows at
//   one byte per cycle while the receiver is ready, and an entity or
//   line end holds tready low until its last byte. A byte without output
//   (a first space or NUL, not at a line end) does not load the emitter.
//   Reset clears the space flags and empties the emitter and the output
//   register. When the receiver stalls, the output register holds its
//   byte and the emitter and then the input stall behind it.

module html_text_line_escaper (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // text_byte[7:0]
    input  logic       i_s_tlast,   // end_of_line
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // out_byte[7:0]
    output logic       o_m_tlast    // out_final
);

    logic r_space_pending;
    logic r_space_run;
    logic n_space_pending;
    logic n_space_run;

    hles_pkg::t_plan plan;
    logic            plan_ready;
    logic            plan_nonempty;
    logic            accept;

    assign o_s_tready = plan_ready;
    assign accept     = i_s_tvalid && plan_ready;

    // plan and next space flags for the offered byte
    always_comb begin
        n_space_pending = r_space_pending;
        n_space_run     = r_space_run;
        plan.lead = hles_pkg::LEAD_NONE;
        plan.body = hles_pkg::BODY_NONE;
        plan.ch   = i_s_tdata;
        plan.tsp  = 1'b0;
        plan.tbr  = 1'b0;

        if (i_s_tdata == hles_pkg::CH_SPACE) begin
            if (r_space_run) begin
                plan.lead = hles_pkg::LEAD_NBSP1;
            end else if (r_space_pending) begin
                plan.lead       = hles_pkg::LEAD_NBSP2;
                n_space_pending = 1'b0;
                n_space_run     = 1'b1;
            end else begin
                n_space_pending = 1'b1;
            end
        end else if (i_s_tdata != hles_pkg::CH_NUL) begin
            plan.lead       = r_space_pending ? hles_pkg::LEAD_SPACE : hles_pkg::LEAD_NONE;
            n_space_pending = 1'b0;
            n_space_run     = 1'b0;
            case (i_s_tdata)
                hles_pkg::CH_AMP:  plan.body = hles_pkg::BODY_AMP;
                hles_pkg::CH_LT:   plan.body = hles_pkg::BODY_LT;
                hles_pkg::CH_GT:   plan.body = hles_pkg::BODY_GT;
                hles_pkg::CH_QUOT: plan.body = hles_pkg::BODY_QUOT;
                hles_pkg::CH_APOS: plan.body = hles_pkg::BODY_APOS;
                hles_pkg::CH_LF:   plan.body = hles_pkg::BODY_BR;
                default:           plan.body = hles_pkg::BODY_PLAIN;
            endcase
        end

        // line end: flush a held space, append the break
        if (i_s_tlast) begin
            plan.tsp        = n_space_pending;
            plan.tbr        = 1'b1;
            n_space_pending = 1'b0;
            n_space_run     = 1'b0;
        end

        plan_nonempty = (plan.lead != hles_pkg::LEAD_NONE) ||
                        (plan.body != hles_pkg::BODY_NONE) || plan.tsp || plan.tbr;
    end

    // space flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_space_pending <= 1'b0;
            r_space_run     <= 1'b0;
        end else if (accept) begin
            r_space_pending <= n_space_pending;
            r_space_run     <= n_space_run;
        end
    end

    hles_emitter u_emitter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_plan_valid (i_s_tvalid && plan_nonempty),
        .o_plan_ready (plan_ready),
        .i_plan       (plan),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tlast    (o_m_tlast)
    );

endmodule

// ===== rtl/hles_emitter.sv =====
// Walks one output plan byte by byte into a registered output stream.
// Depends on hles_pkg (t_plan, phase codes, text tables).

module hles_emitter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_plan_valid,
    output logic                  o_plan_ready,
    input  hles_pkg::t_plan       i_plan,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [7:0]            o_m_tdata,  // out_byte[7:0]
    output logic                  o_m_tlast   // out_final
);

    logic            r_busy;
    hles_pkg::t_plan r_plan;
    logic [1:0]      r_ph;
    logic [3:0]      r_idx;
    logic            r_out_valid;
    logic [7:0]      r_out_byte;
    logic            r_out_last;

    logic [3:0] cur_len;
    logic       at_end;
    logic       has_next;
    logic [1:0] next_ph;
    logic       last;
    logic       emit;
    logic [1:0] first_ph;

    // current phase position and the next nonempty phase
    always_comb begin
        cur_len  = hles_pkg::seg_len(r_plan, r_ph);
        at_end   = (r_idx == cur_len - 4'd1);
        has_next = 1'b0;
        next_ph  = r_ph;
        for (int p = 3; p >= 0; p--) begin
            if ((2'(p) > r_ph) && (hles_pkg::seg_len(r_plan, 2'(p)) != 4'd0)) begin
                has_next = 1'b1;
                next_ph  = 2'(p);
            end
        end
        last = at_end && !has_next;
    end

    // first nonempty phase of an incoming plan
    always_comb begin
        first_ph = hles_pkg::PH_TBR;
        for (int p = 3; p >= 0; p--) begin
            if (hles_pkg::seg_len(i_plan, 2'(p)) != 4'd0) begin
                first_ph = 2'(p);
            end
        end
    end

    assign emit         = r_busy && (!r_out_valid || i_m_tready);
    assign o_plan_ready = !r_busy || (emit && last);

    // plan sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_plan_valid && o_plan_ready) begin
            r_busy <= 1'b1;
            r_plan <= i_plan;
            r_ph   <= first_ph;
            r_idx  <= 4'd0;
        end else if (emit) begin
            if (last) begin
                r_busy <= 1'b0;
            end else if (at_end) begin
                r_ph  <= next_ph;
                r_idx <= 4'd0;
            end else begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
            r_out_byte  <= hles_pkg::seg_char(r_plan, r_ph, r_idx);
            r_out_last  <= last;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;

endmodule
